// ===== rtl/imm_pkg.sv =====
// Shared types and constants for the integer matrix multiply block.
// Used by imm_cell, imm_feed and integer_matrix_multiply; no dependencies.
`timescale 1ns / 1ps

package imm_pkg;

   localparam int ELEM_W          = 32;   // element and result width
   localparam int PROD_W          = 64;   // full signed product width
   localparam int IDX_W           = 3;    // row and column field width
   localparam int SIZE_W          = 4;    // size register width
   localparam int MAX_DIM_DEFAULT = 8;
   localparam int CALC_W          = 8;    // scratch width for index compares
   localparam int ADDR_CALC_W     = 16;   // scratch width for row * dim + col

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   localparam logic [1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // Control that travels with one term down the cell chain.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } term_ctl_type;

   // One finished element of C.
   typedef struct packed {
      logic              wrapped;
      logic [ELEM_W-1:0] value;
   } res_type;

   // Write of one element of the right matrix.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [ELEM_W-1:0] data;
   } bwr_type;

endpackage

// ===== rtl/imm_cell.sv =====
// One multiply-accumulate cell of the chain: owns one column of B.
// Depends on imm_pkg.
`timescale 1ns / 1ps

module imm_cell
   import imm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  term_ctl_type             in_ctl,
   input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] in_k,
   input  logic signed [ELEM_W-1:0] in_a,
   output term_ctl_type             out_ctl,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] out_k,
   output logic signed [ELEM_W-1:0] out_a,
   input  logic                     b_wr_en,
   input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] b_wr_addr,
   input  logic [ELEM_W-1:0]        b_wr_data,
   output logic                     acc_done,
   input  logic                     capture,
   input  logic                     shift,
   input  res_type                  res_in,
   output res_type                  res_out
);

   localparam int K_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ACC_W = PROD_W + $clog2(MAX_DIM);

   logic [ELEM_W-1:0]        b_mem [0:MAX_DIM-1];
   logic signed [ELEM_W-1:0] b_rd_ff;
   term_ctl_type             s1_ctl_ff;
   logic [K_W-1:0]           s1_k_ff;
   logic signed [ELEM_W-1:0] s1_a_ff;
   term_ctl_type             s2_ctl_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     done_ff;
   res_type                  res_ff;
   logic                     fits;

   always_ff @(posedge clock) begin
      if (b_wr_en) begin
         b_mem[b_wr_addr] <= b_wr_data;
      end
      b_rd_ff <= b_mem[in_k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         s1_ctl_ff <= in_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         done_ff   <= s2_ctl_ff.valid & s2_ctl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      s1_k_ff <= in_k;
      s1_a_ff <= in_a;
      prod_ff <= PROD_W'(s1_a_ff) * PROD_W'(b_rd_ff);
      if (s2_ctl_ff.valid) begin
         if (s2_ctl_ff.first) begin
            acc_ff <= ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // The sum fits 32 signed bits when every bit from 31 upward agrees.
   assign fits = (&acc_ff[ACC_W-1:ELEM_W-1]) | ~(|acc_ff[ACC_W-1:ELEM_W-1]);

   always_ff @(posedge clock) begin
      if (capture) begin
         res_ff.wrapped <= ~fits;
         res_ff.value   <= acc_ff[ELEM_W-1:0];
      end else if (shift) begin
         res_ff <= res_in;
      end
   end

   assign out_ctl  = s1_ctl_ff;
   assign out_k    = s1_k_ff;
   assign out_a    = s1_a_ff;
   assign acc_done = done_ff;
   assign res_out  = res_ff;

endmodule

// ===== rtl/imm_feed.sv =====
// Command decoder and row sequencer: holds matrix A, streams one row into the chain.
// Depends on imm_pkg.
`timescale 1ns / 1ps

module imm_feed
   import imm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   input  logic [$clog2(MAX_DIM+1)-1:0] eff_size,
   input  logic                     out_busy,
   input  logic                     chain_done,
   output term_ctl_type             term_ctl,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] term_k,
   output logic signed [ELEM_W-1:0] term_a,
   output bwr_type                  b_wr,
   output logic                     cap,
   output logic [IDX_W-1:0]         cap_row,
   output logic [$clog2(MAX_DIM+1)-1:0] cap_n
);

   localparam int K_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_FLUSH,
      ST_HOLD
   } state_type;

   state_type                state_ff;
   logic [IDX_W-1:0]         row_ff;
   logic [DIM_W-1:0]         n_ff;
   logic [K_W-1:0]           k_ff;
   term_ctl_type             rd_ctl_ff;
   logic [K_W-1:0]           rd_k_ff;
   logic cap_ff;
   logic [ELEM_W-1:0]        a_mem [0:DEPTH-1];
   logic signed [ELEM_W-1:0] a_rd_ff;

   logic                   accept;
   logic                   in_store;
   logic                   start;
   logic                   a_wr_en;
   logic                   k_last;
   logic [ADDR_CALC_W-1:0] wr_calc;
   logic [ADDR_CALC_W-1:0] rd_calc;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign in_store  = (CALC_W'(req_row_index) < CALC_W'(MAX_DIM)) &&
                      (CALC_W'(req_col_index) < CALC_W'(MAX_DIM));
   assign wr_calc   = ADDR_CALC_W'(req_row_index) * ADDR_CALC_W'(MAX_DIM) +
                      ADDR_CALC_W'(req_col_index);
   assign rd_calc   = ADDR_CALC_W'(row_ff) * ADDR_CALC_W'(MAX_DIM) + ADDR_CALC_W'(k_ff);
   assign a_wr_en   = accept && (req_command == CMD_LOAD_A) && in_store;
   assign start     = accept && (req_command == CMD_COMPUTE) &&
                      (CALC_W'(req_row_index) < CALC_W'(eff_size));
   assign k_last    = (CALC_W'(k_ff) == (CALC_W'(n_ff) - CALC_W'(1)));

   always_comb begin
      b_wr.en   = accept && (req_command == CMD_LOAD_B) && in_store;
      b_wr.row  = req_row_index;
      b_wr.col  = req_col_index;
      b_wr.data = req_element_value;
   end

   always_ff @(posedge clock) begin
      if (a_wr_en) begin
         a_mem[wr_calc[ADDR_W-1:0]] <= req_element_value;
      end
      a_rd_ff <= a_mem[rd_calc[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_ctl_ff <= '0;
         cap_ff    <= 1'b0;
      end else begin
         rd_ctl_ff.valid <= (state_ff == ST_FEED);
         rd_ctl_ff.first <= (k_ff == '0);
         rd_ctl_ff.last  <= k_last;
         rd_k_ff         <= k_ff;
         cap_ff          <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  row_ff   <= req_row_index;
                  n_ff     <= eff_size;
                  k_ff     <= '0;
                  state_ff <= ST_FEED;
               end
            end
            ST_FEED: begin
               k_ff <= k_ff + K_W'(1);
               if (k_last) begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               if (chain_done) begin
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (!out_busy) begin
                  cap_ff   <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign term_ctl = rd_ctl_ff;
   assign term_k   = rd_k_ff;
   assign term_a   = a_rd_ff;
   assign cap      = cap_ff;
   assign cap_row  = row_ff;
   assign cap_n    = n_ff;

endmodule

// ===== rtl/integer_matrix_multiply.sv =====
// Top level of the signed integer matrix multiply: size register, cell chain, result port.
// Depends on imm_pkg, imm_feed and imm_cell.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake              | Carries
//  csr     | in        | csr_valid / csr_ready  | size_in_use (4 bits)
//  req     | in        | req_valid / req_ready  | command, row, column, element value
//  rsp     | out       | rsp_valid / rsp_ready  | product, row, column, row_last, wrapped
//
// A load is a single request. A compute of an n-wide row holds the request channel
// while the n terms of the A row are read, pass down the cell chain to the last used
// column, go through read, multiply and accumulate, and the row is then captured.
// The n results leave one per cycle while rsp_ready is high; new requests are accepted.
// Reset is synchronous and clears the control state; the matrices hold no reset value.
// A stall on rsp only delays the capture of the next compute's row.

module integer_matrix_multiply
   import imm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [SIZE_W-1:0]        csr_size_in_use,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ELEM_W-1:0] rsp_product_value,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic                     rsp_row_last,
   output logic                     rsp_wrapped
);

   localparam int K_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [SIZE_W-1:0] size_ff;
   logic [CALC_W-1:0] size8;
   logic [CALC_W-1:0] eff8;
   logic [DIM_W-1:0]  eff_size;

   // Result port state.
   logic [DIM_W-1:0]  count_ff;
   logic [K_W-1:0]    col_ff;
   logic [IDX_W-1:0]  row_ff;
   logic [CALC_W-1:0] col8;
   logic              out_busy;
   logic              transfer;

   // Chain wiring; position 0 is the sequencer's output.
   term_ctl_type             chain_ctl [0:MAX_DIM];
   logic [K_W-1:0]           chain_k   [0:MAX_DIM];
   logic signed [ELEM_W-1:0] chain_a   [0:MAX_DIM];
   res_type                  res_vec   [0:MAX_DIM];
   logic [MAX_DIM-1:0]       done_vec;

   bwr_type           b_wr;
   logic [CALC_W-1:0] b_row8;
   logic              cap;
   logic [IDX_W-1:0]  cap_row;
   logic [DIM_W-1:0]  cap_n;
   logic [DIM_W-1:0]  n_minus1;
   logic              chain_done;

   // Write the size register only while the block is idle; always ready, so not enforced.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_size_in_use;
      end
   end

   // A size of zero acts as one, and a size above the storage acts as the storage size.
   assign size8 = CALC_W'(size_ff);
   always_comb begin
      if (size8 == '0) begin
         eff8 = CALC_W'(1);
      end else if (size8 > CALC_W'(MAX_DIM)) begin
         eff8 = CALC_W'(MAX_DIM);
      end else begin
         eff8 = size8;
      end
   end
   assign eff_size = eff8[DIM_W-1:0];

   imm_feed #(
      .MAX_DIM (MAX_DIM)
   ) u_feed (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .eff_size          (eff_size),
      .out_busy          (out_busy),
      .chain_done        (chain_done),
      .term_ctl          (chain_ctl[0]),
      .term_k            (chain_k[0]),
      .term_a            (chain_a[0]),
      .b_wr              (b_wr),
      .cap               (cap),
      .cap_row           (cap_row),
      .cap_n             (cap_n)
   );

   // Every cell sees every term of the A row in the cycle after its left neighbor, so
   // the cell of the last used column finishes last. Its done pulse ends the compute.
   // Done pulses that cells beyond the used width raise for an earlier, narrower
   // compute have long passed by the time the next compute waits for its own pulse.
   assign n_minus1   = cap_n - DIM_W'(1);
   assign chain_done = done_vec[n_minus1[K_W-1:0]];

   assign b_row8         = CALC_W'(b_wr.row);
   assign res_vec[MAX_DIM] = '0;

   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      logic b_en;

      // A load of B goes only to the cell that owns that column.
      assign b_en = b_wr.en && (CALC_W'(b_wr.col) == CALC_W'(j));

      imm_cell #(
         .MAX_DIM (MAX_DIM)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (chain_ctl[j]),
         .in_k      (chain_k[j]),
         .in_a      (chain_a[j]),
         .out_ctl   (chain_ctl[j+1]),
         .out_k     (chain_k[j+1]),
         .out_a     (chain_a[j+1]),
         .b_wr_en   (b_en),
         .b_wr_addr (b_row8[K_W-1:0]),
         .b_wr_data (b_wr.data),
         .acc_done  (done_vec[j]),
         .capture   (cap),
         .shift     (transfer),
         .res_in    (res_vec[j+1]),
         .res_out   (res_vec[j])
      );
   end

   // The captured row sits in the cells' result registers and shifts toward cell 0,
   // one column per transfer. The count says how many columns of it are still to go.
   assign rsp_valid = (count_ff != '0);
   assign transfer  = rsp_valid & rsp_ready;
   assign out_busy  = rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cap) begin
         count_ff <= cap_n;
      end else if (transfer) begin
         count_ff <= count_ff - DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cap) begin
         row_ff <= cap_row;
         col_ff <= '0;
      end else if (transfer) begin
         col_ff <= col_ff + K_W'(1);
      end
   end

   assign col8              = CALC_W'(col_ff);
   assign rsp_product_value = res_vec[0].value;
   assign rsp_wrapped       = res_vec[0].wrapped;
   assign rsp_out_row       = row_ff;
   assign rsp_out_col       = col8[IDX_W-1:0];
   assign rsp_row_last      = (count_ff == DIM_W'(1));

   // A new row is captured only into an empty result chain.
   a_capture_empty : assert property (@(posedge clock) disable iff (reset)
      cap |-> (count_ff == '0))
      else $error("row captured while results were still pending");

   // The chain is fed only while the request channel is held off.
   a_feed_blocks_req : assert property (@(posedge clock) disable iff (reset)
      chain_ctl[0].valid |-> !req_ready)
      else $error("term entered the chain while requests were accepted");

   // After the last column of a row leaves, the result port goes empty.
   a_last_empties : assert property (@(posedge clock) disable iff (reset)
      (transfer && rsp_row_last) |=> !rsp_valid)
      else $error("result port not empty after the last column");

endmodule
